### rtl/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg: shared types for the distinct set intersection block
// Request and status codes, and the token that walks the cell row.
// ----------------------------------------------------------------------------
package dsi_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_PROBE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISS    = 3'd3,
    ST_REPEAT  = 3'd4,
    ST_COMMON  = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

  localparam int unsigned VALUE_W = 32;

  // One request in flight along the row, with what the cells found so far
  typedef struct packed {
    logic               vld;
    req_t               kind;
    logic [VALUE_W-1:0] value;
    logic               found;   // matched a valid entry
    logic               rep;     // matched entry had already been reported
    logic               placed;  // load written into a free entry
  } token_t;

endpackage

### rtl/dsi_cell.sv
// ----------------------------------------------------------------------------
// dsi_cell: one table entry of the membership row
// Holds one value with valid and reported flags, updates them from the
// passing token and hands the token on to the next cell through a register.
// ----------------------------------------------------------------------------
module dsi_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dsi_pkg::token_t tok_i,
  output dsi_pkg::token_t tok_o,
  output logic            ent_vld_o
);

  logic [dsi_pkg::VALUE_W-1:0] ent_val_r, ent_val_nxt;
  logic                        ent_vld_r, ent_vld_nxt;
  logic                        ent_rep_r, ent_rep_nxt;
  dsi_pkg::token_t             tok_r, tok_nxt;
  logic                        match;

  assign match = ent_vld_r && (ent_val_r == tok_i.value);

  always_comb begin
    ent_val_nxt = ent_val_r;
    ent_vld_nxt = ent_vld_r;
    ent_rep_nxt = ent_rep_r;
    tok_nxt     = tok_i;
    if (tok_i.vld) begin
      case (tok_i.kind)
        dsi_pkg::REQ_CLEAR: begin
          ent_vld_nxt = 1'b0;
          ent_rep_nxt = 1'b0;
        end
        dsi_pkg::REQ_LOAD: begin
          if (match) begin
            tok_nxt.found = 1'b1;
          end else if (!ent_vld_r && !tok_i.found && !tok_i.placed) begin
            // valid entries form a prefix, so every live entry has been checked
            ent_val_nxt    = tok_i.value;
            ent_vld_nxt    = 1'b1;
            ent_rep_nxt    = 1'b0;
            tok_nxt.placed = 1'b1;
          end
        end
        dsi_pkg::REQ_PROBE: begin
          if (match) begin
            tok_nxt.found = 1'b1;
            tok_nxt.rep   = ent_rep_r;
            ent_rep_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_val_r <= ent_val_nxt;
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      ent_rep_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
      ent_rep_r <= ent_rep_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_o     = tok_r;
  assign ent_vld_o = ent_vld_r;

endmodule

### rtl/distinct_set_intersection_top.sv
// ----------------------------------------------------------------------------
// distinct_set_intersection_top: membership table for a set intersection
// Loads build the first set, probes report each common element once.
//
//   channel   ports                                   dir   handshake
//   input     in_req_type, in_value                   in    start & !busy
//   result    out_status, out_value_out               out   out_valid strobe
//
// Each beat walks the row of CAPACITY cells, one cell per cycle, through each
// cell's token register and then the output register. A new beat is taken every
// cycle (busy stays low), as tokens never overtake each other in the row.
// Request code 3 is taken and dropped without a result.
// Synchronous reset empties the table; entry values themselves are not reset.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module distinct_set_intersection_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic signed [dsi_pkg::VALUE_W-1:0] in_value,
  output logic                             out_valid,
  output logic [2:0]                       out_status,
  output logic signed [dsi_pkg::VALUE_W-1:0] out_value_out
);

  dsi_pkg::token_t             chain [0:CAPACITY];
  logic [CAPACITY-1:0]         valid_vec;
  logic                        in_take;
  dsi_pkg::token_t             last;
  dsi_pkg::status_t            status_nxt;
  logic                        out_valid_r;
  dsi_pkg::status_t            out_status_r;
  logic [dsi_pkg::VALUE_W-1:0] out_value_r;

  assign busy    = 1'b0;
  assign in_take = start && !busy && rst_n
                   && (dsi_pkg::req_t'(in_req_type) != dsi_pkg::REQ_NONE);

  always_comb begin
    chain[0].vld    = in_take;
    chain[0].kind   = dsi_pkg::req_t'(in_req_type);
    chain[0].value  = in_value;
    chain[0].found  = 1'b0;
    chain[0].rep    = 1'b0;
    chain[0].placed = 1'b0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dsi_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1]),
      .ent_vld_o (valid_vec[i])
    );
  end

  assign last = chain[CAPACITY];

  always_comb begin
    case (last.kind)
      dsi_pkg::REQ_CLEAR: status_nxt = dsi_pkg::ST_CLEARED;
      dsi_pkg::REQ_LOAD: begin
        if (last.found)       status_nxt = dsi_pkg::ST_DUP;
        else if (last.placed) status_nxt = dsi_pkg::ST_LOADED;
        else                  status_nxt = dsi_pkg::ST_FULL;
      end
      dsi_pkg::REQ_PROBE: begin
        if (!last.found)   status_nxt = dsi_pkg::ST_MISS;
        else if (last.rep) status_nxt = dsi_pkg::ST_REPEAT;
        else               status_nxt = dsi_pkg::ST_COMMON;
      end
      default: status_nxt = dsi_pkg::ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    out_status_r <= status_nxt;
    out_value_r  <= last.value;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

`ifndef ASSERT_OFF
  // every taken beat yields its result after the full row walk
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##(CAPACITY + 1) out_valid)
    else $error("result strobe out of step with accepted beats");

  // a load that leaves the row unplaced and unmatched saw the last entry in use
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (last.vld && last.kind == dsi_pkg::REQ_LOAD && !last.found && !last.placed)
    |-> valid_vec[CAPACITY-1])
    else $error("load reported full while the last entry was free");

  // result status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= dsi_pkg::ST_CLEARED))
    else $error("result status out of range");
`endif

endmodule

### bench/distinct_set_intersection_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distinct_set_intersection_top_tb: self-checking bench for the set table
// Walks a short table of directed beats, fills the table to capacity, then
// runs random clear/load/probe sequences with noise. Results are checked in send
// order, against typed answers (directed) or a local table model (random).
// ----------------------------------------------------------------------------
module distinct_set_intersection_top_tb;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned RAND_BEATS = 1000;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef struct {
    dsi_pkg::status_t status;
    logic [31:0]      value;
  } result_t;

  typedef struct {
    dsi_pkg::req_t    req;
    logic [31:0]      value;
    dsi_pkg::status_t status;  // typed-in answer
  } step_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_req_type;
  logic signed [31:0]  in_value;
  logic                out_valid;
  logic [2:0]          out_status;
  logic signed [31:0]  out_value_out;

  // local copy of the membership table
  logic [31:0]         set_value    [DEPTH];
  bit                  set_valid    [DEPTH];
  bit                  set_reported [DEPTH];
  int unsigned         set_fill;

  result_t             pending_results[$];
  result_t             head_r;
  int unsigned         fail_count;
  int unsigned         cycle_count;
  int unsigned         beats_sent;
  bit                  idle_on;
  bit                  quiet;

  distinct_set_intersection_top #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_value_out(out_value_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Works out the status of one beat and updates the table copy.
  // Returns 0 for the unused request code, which gives no result.
  function automatic bit table_predict(input dsi_pkg::req_t req, input logic [31:0] val,
                                       output dsi_pkg::status_t st);
    int hit;
    hit = -1;
    st  = dsi_pkg::ST_MISS;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && set_valid[i] && set_value[i] == val) hit = i;
    end
    case (req)
      dsi_pkg::REQ_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) begin
          set_valid[i]    = 1'b0;
          set_reported[i] = 1'b0;
        end
        set_fill = 0;
        st = dsi_pkg::ST_CLEARED;
      end
      dsi_pkg::REQ_LOAD: begin
        if (hit >= 0) begin
          st = dsi_pkg::ST_DUP;
        end else if (set_fill >= DEPTH) begin
          st = dsi_pkg::ST_FULL;
        end else begin
          set_value[set_fill]    = val;
          set_valid[set_fill]    = 1'b1;
          set_reported[set_fill] = 1'b0;
          set_fill++;
          st = dsi_pkg::ST_LOADED;
        end
      end
      dsi_pkg::REQ_PROBE: begin
        if (hit < 0) begin
          st = dsi_pkg::ST_MISS;
        end else if (set_reported[hit]) begin
          st = dsi_pkg::ST_REPEAT;
        end else begin
          set_reported[hit] = 1'b1;
          st = dsi_pkg::ST_COMMON;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] corners [4];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Drives one beat, waits for it to be taken and queues its answer.
  // use_typed: take st_typed as the answer rather than the model's.
  task automatic send_beat(input dsi_pkg::req_t req, input logic [31:0] val,
                           input bit use_typed, input dsi_pkg::status_t st_typed);
    dsi_pkg::status_t st;
    bit               has_res;
    result_t          res;
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    has_res = table_predict(req, val, st);
    if (has_res) begin
      beats_sent++;
      res.status = use_typed ? st_typed : st;
      res.value  = val;
      pending_results.insert(pending_results.size(), res);
    end
  endtask

  // result checker: the receiver never stalls, so every strobe is a beat
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_status %0d, out_value_out %h",
               out_status, out_value_out);
        fail_count++;
      end else begin
        head_r = pending_results.pop_front();
        if (out_status !== head_r.status) begin
          $error("out_status: expected %0d, got %0d", head_r.status, out_status);
          fail_count++;
        end
        if (out_value_out !== head_r.value) begin
          $error("out_value_out: expected %h, got %h", head_r.value, out_value_out);
          fail_count++;
        end
      end
    end
  end

  initial begin
    step_t       steps [$];
    logic [31:0] pool [$];
    int unsigned rand_base;
    int unsigned n_load;
    int unsigned n_probe;
    int unsigned n_pool;
    bit          drained;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = dsi_pkg::REQ_NONE;
    in_value    = '0;
    fail_count  = 0;
    cycle_count = 0;
    beats_sent  = 0;
    idle_on     = 1'b1;
    quiet       = 1'b0;
    drained     = 1'b0;
    set_fill    = 0;
    for (int i = 0; i < DEPTH; i++) begin
      set_valid[i]    = 1'b0;
      set_reported[i] = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    steps = '{
      '{dsi_pkg::REQ_PROBE, 32'h0000_0000, dsi_pkg::ST_MISS},     // empty table
      '{dsi_pkg::REQ_LOAD,  32'h8000_0000, dsi_pkg::ST_LOADED},
      '{dsi_pkg::REQ_LOAD,  32'h7FFF_FFFF, dsi_pkg::ST_LOADED},
      '{dsi_pkg::REQ_LOAD,  32'h0000_0000, dsi_pkg::ST_LOADED},
      '{dsi_pkg::REQ_LOAD,  32'hFFFF_FFFF, dsi_pkg::ST_LOADED},
      '{dsi_pkg::REQ_LOAD,  32'h7FFF_FFFF, dsi_pkg::ST_DUP},
      '{dsi_pkg::REQ_PROBE, 32'h8000_0000, dsi_pkg::ST_COMMON},
      '{dsi_pkg::REQ_PROBE, 32'h8000_0000, dsi_pkg::ST_REPEAT},
      '{dsi_pkg::REQ_LOAD,  32'h8000_0000, dsi_pkg::ST_DUP},      // reload of reported value
      '{dsi_pkg::REQ_PROBE, 32'h8000_0000, dsi_pkg::ST_REPEAT},   // still reported
      '{dsi_pkg::REQ_NONE,  32'h1234_5678, dsi_pkg::ST_MISS},     // dropped, no result
      '{dsi_pkg::REQ_PROBE, 32'h7FFF_FFFE, dsi_pkg::ST_MISS},
      '{dsi_pkg::REQ_PROBE, 32'hFFFF_FFFF, dsi_pkg::ST_COMMON},
      '{dsi_pkg::REQ_CLEAR, 32'hA5A5_A5A5, dsi_pkg::ST_CLEARED},
      '{dsi_pkg::REQ_PROBE, 32'h7FFF_FFFF, dsi_pkg::ST_MISS},
      '{dsi_pkg::REQ_LOAD,  32'h8000_0000, dsi_pkg::ST_LOADED},
      '{dsi_pkg::REQ_PROBE, 32'h8000_0000, dsi_pkg::ST_COMMON},   // reported bit gone after clear
      '{dsi_pkg::REQ_CLEAR, 32'h5A5A_5A5A, dsi_pkg::ST_CLEARED},
      '{dsi_pkg::REQ_NONE,  32'hFFFF_FFFF, dsi_pkg::ST_MISS}
    };
    foreach (steps[k]) send_beat(steps[k].req, steps[k].value, 1'b1, steps[k].status);

    // fill to capacity, then the full-table cases
    for (int i = 0; i < DEPTH; i++)
      send_beat(dsi_pkg::REQ_LOAD, 32'hF000_0000 | i, 1'b1, dsi_pkg::ST_LOADED);
    send_beat(dsi_pkg::REQ_LOAD,  32'h0F00_0000, 1'b1, dsi_pkg::ST_FULL);
    send_beat(dsi_pkg::REQ_LOAD,  32'hF000_0000, 1'b1, dsi_pkg::ST_DUP);
    send_beat(dsi_pkg::REQ_PROBE, 32'hF000_0000 | (DEPTH - 1), 1'b1, dsi_pkg::ST_COMMON);
    send_beat(dsi_pkg::REQ_PROBE, 32'h0F00_0000, 1'b1, dsi_pkg::ST_MISS);

    rand_base = beats_sent;
    while (beats_sent - rand_base < RAND_BEATS) begin
      idle_on = ($urandom_range(0, 2) != 0);
      quiet   = (beats_sent - rand_base > RAND_BEATS * 85 / 100);
      if (!drained && beats_sent - rand_base > RAND_BEATS / 2) begin
        // hold off until the row has emptied
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        8: begin
          // noise: any request code, any value
          repeat ($urandom_range(1, 8))
            send_beat(dsi_pkg::req_t'($urandom_range(0, 3)), pick_value(), 1'b0,
                      dsi_pkg::ST_MISS);
        end
        9: begin
          // broken sequence: no clear, small value pool
          pool.delete();
          repeat (4) pool.insert(pool.size(), pick_value());
          repeat ($urandom_range(2, 12))
            send_beat(($urandom_range(0, 1) != 0) ? dsi_pkg::REQ_LOAD : dsi_pkg::REQ_PROBE,
                      pool[$urandom_range(0, 3)], 1'b0, dsi_pkg::ST_MISS);
        end
        default: begin
          // clear, build the first set, probe with the second
          n_load  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 16);
          n_pool  = n_load + $urandom_range(0, 6);
          n_probe = $urandom_range(1, 2 * n_load + 4);
          pool.delete();
          repeat (n_pool) pool.insert(pool.size(), pick_value());
          send_beat(dsi_pkg::REQ_CLEAR, pick_value(), 1'b0, dsi_pkg::ST_MISS);
          repeat (n_load)
            send_beat(dsi_pkg::REQ_LOAD, pool[$urandom_range(0, n_pool - 1)], 1'b0,
                      dsi_pkg::ST_MISS);
          repeat (n_probe) begin
            if ($urandom_range(0, 4) == 0)
              send_beat(dsi_pkg::REQ_PROBE, pick_value(), 1'b0, dsi_pkg::ST_MISS);
            else
              send_beat(dsi_pkg::REQ_PROBE, pool[$urandom_range(0, n_pool - 1)], 1'b0,
                        dsi_pkg::ST_MISS);
          end
        end
      endcase
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
